// ----- design/sdf_pkg.sv -----
// Shared types and constants of the substring deletion filter.
package sdf_pkg;

	// Width of one text byte.
	localparam int BYTE_W = 8;

	// Width of the configuration data and register index.
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

	// Width of the stored pattern length.
	localparam int LEN_W = 5;

	// Per-cycle window command shared by all cells.
	typedef struct packed {
		logic              shift;
		logic              append;
		logic [BYTE_W-1:0] data;
	} cell_ctl_t;

	// Sequencer state: taking a new byte, or flushing the window at end of text.
	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} sdf_state_t;

endpackage

// ----- design/sdf_cell.sv -----
// One window cell: holds a byte and its valid mark and compares its next contents with its pattern byte.
module sdf_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdf_pkg::cell_ctl_t        ctl,
	input  logic                      wipe,
	input  logic [sdf_pkg::BYTE_W-1:0] nxt_byte,
	input  logic                      nxt_valid,
	input  logic                      prv_valid,
	input  logic [sdf_pkg::BYTE_W-1:0] pat_byte,
	input  logic                      match_in,
	output logic [sdf_pkg::BYTE_W-1:0] cell_byte,
	output logic                      cell_valid,
	output logic                      match_out
);
	import sdf_pkg::*;

	logic [BYTE_W-1:0] byte_q;
	logic              valid_q;
	logic              free_slot;
	logic              load;
	logic [BYTE_W-1:0] byte_d;
	logic              valid_d;

	// Next contents: shift from the right neighbor, or take the new byte
	// when this cell is the first free slot of the window.
	always_comb begin
		if (ctl.shift) begin
			free_slot = valid_q && !nxt_valid;
		end else begin
			free_slot = !valid_q && prv_valid;
		end
		load = ctl.append && free_slot;
		if (load) begin
			byte_d  = ctl.data;
			valid_d = 1'b1;
		end else if (ctl.shift) begin
			byte_d  = nxt_byte;
			valid_d = nxt_valid;
		end else begin
			byte_d  = byte_q;
			valid_d = valid_q;
		end
	end

	// An empty cell never breaks the match chain.
	assign match_out = match_in && (!valid_d || (byte_d == pat_byte));

	// Valid mark; a match wipes the whole window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d && !wipe;
		end
	end

	// Byte payload.
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	assign cell_byte  = byte_q;
	assign cell_valid = valid_q;

endmodule

// ----- design/substring_deletion_filter.sv -----
// Top level of the substring deletion filter: config registers, sequencer, cell row, output register.
//
// Streams a text one byte per beat and passes it on with every leftmost,
// non-overlapping occurrence of the configured pattern (1 to PATTERN_MAX
// bytes, first byte in bits 7:0 of register 0) removed. The most recent
// bytes sit in a row of PATTERN_MAX cells that shift toward cell 0 and
// compare against the pattern in parallel, so the block sustains one byte
// per cycle while the output is not stalled. Bytes leave only through
// cell 0, at most one per cycle: a byte that arrives after the pattern length
// was lowered waits while the surplus window bytes are popped out first, and
// the last byte of a text (tlast) is held while the bytes left in the
// window after it is added are flushed out. When nothing is left to send
// at the end of a text, a single beat with tuser low and tlast high closes
// it. An accepted byte waits in a holding register and results pass
// through an output register.
module substring_deletion_filter #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdf_pkg::CFG_W-1:0]     cfg_data,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] in_byte
	input  logic                          s_tlast,   // in_last
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] out_byte
	output logic                          m_tuser,   // [0] byte_present
	output logic                          m_tlast    // out_last
);
	import sdf_pkg::*;

	localparam int CW = $clog2(PATTERN_MAX + 1);

	// Configuration registers.
	logic [CFG_W-1:0]   pat_lo_q;
	logic [CFG_W-1:0]   pat_hi_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [2*CFG_W-1:0] pat_all;

	// Holding register for the byte in work.
	logic              pend_valid_q;
	logic [BYTE_W-1:0] pend_byte_q;
	logic              pend_last_q;

	// Sequencer.
	sdf_state_t st_q;
	sdf_state_t st_d;
	logic [CW-1:0] n_q;
	logic [CW-1:0] n_mid;
	logic [CW-1:0] n_fin;
	logic [CW-1:0] len_act;
	logic          out_free;
	logic          go;
	logic          done;
	logic          wipe;
	cell_ctl_t     ctl;

	// Result of the current cycle.
	logic              emit;
	logic              emit_present;
	logic              emit_last;
	logic [BYTE_W-1:0] emit_byte;

	// Output register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_present_q;
	logic              out_last_q;

	// Cell row wiring.
	logic [BYTE_W-1:0]      cell_byte [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] valid_vec;
	logic [PATTERN_MAX:0]   match_c;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LO:  pat_lo_q  <= cfg_data;
				REG_PAT_HI:  pat_hi_q  <= cfg_data;
				REG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_hi_q, pat_lo_q};

	// Length in use: zero acts as one, large values clamp to the cell count.
	always_comb begin
		if (pat_len_q == '0) begin
			len_act = CW'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			len_act = CW'(PATTERN_MAX);
		end else begin
			len_act = CW'(pat_len_q);
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign go       = pend_valid_q && out_free;

	// Window command: pop surplus bytes, pop and append when full, append otherwise; pop only while flushing.
	always_comb begin
		ctl.shift  = 1'b0;
		ctl.append = 1'b0;
		ctl.data   = pend_byte_q;
		n_mid      = n_q;
		if (go) begin
			unique case (st_q)
				ST_RUN: begin
					if (n_q > len_act) begin
						ctl.shift = 1'b1;
						n_mid     = CW'(n_q - 1'b1);
					end else if (n_q == len_act) begin
						ctl.shift  = 1'b1;
						ctl.append = 1'b1;
					end else begin
						ctl.append = 1'b1;
						n_mid      = CW'(n_q + 1'b1);
					end
				end
				ST_FLUSH: begin
					ctl.shift = 1'b1;
					n_mid     = CW'(n_q - 1'b1);
				end
				default: ;
			endcase
		end
	end

	// Next state, match wipe, and the result beat of this cycle.
	always_comb begin
		st_d         = st_q;
		wipe         = 1'b0;
		n_fin        = n_mid;
		done         = 1'b0;
		emit         = 1'b0;
		emit_present = 1'b1;
		emit_last    = 1'b0;
		if (go) begin
			unique case (st_q)
				ST_RUN: begin
					emit = ctl.shift;
					if (ctl.append) begin
						wipe = (n_mid == len_act) && match_c[PATTERN_MAX];
						if (wipe) begin
							n_fin = '0;
						end
						if (!pend_last_q) begin
							done = 1'b1;
						end else if (n_fin == '0) begin
							// End of text with an empty window closes here,
							// with an empty marker if no byte goes out.
							emit         = 1'b1;
							emit_present = ctl.shift;
							emit_last    = 1'b1;
							done         = 1'b1;
						end else begin
							st_d = ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					emit = 1'b1;
					if (n_q == CW'(1)) begin
						emit_last = 1'b1;
						done      = 1'b1;
						st_d      = ST_RUN;
					end
				end
				default: ;
			endcase
		end
		emit_byte = emit_present ? cell_byte[0] : '0;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			n_q  <= '0;
		end else begin
			st_q <= st_d;
			n_q  <= n_fin;
		end
	end

	// Holding register: a new beat enters as the previous byte finishes.
	assign s_tready = !pend_valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			pend_valid_q <= 1'b1;
		end else if (done) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pend_byte_q <= s_tdata;
			pend_last_q <= s_tlast;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q    <= emit_byte;
			out_present_q <= emit_present;
			out_last_q    <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_present_q;
	assign m_tlast  = out_last_q;

	// Row of window cells, cell 0 holding the oldest byte.
	assign match_c[0] = 1'b1;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [BYTE_W-1:0] nb;
		logic              nv;
		logic              pv;

		if (i == PATTERN_MAX - 1) begin : g_end
			assign nb = '0;
			assign nv = 1'b0;
		end else begin : g_mid
			assign nb = cell_byte[i+1];
			assign nv = valid_vec[i+1];
		end

		if (i == 0) begin : g_head
			assign pv = 1'b1;
		end else begin : g_body
			assign pv = valid_vec[i-1];
		end

		sdf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wipe      (wipe),
			.nxt_byte  (nb),
			.nxt_valid (nv),
			.prv_valid (pv),
			.pat_byte  (pat_all[BYTE_W*i +: BYTE_W]),
			.match_in  (match_c[i]),
			.cell_byte (cell_byte[i]),
			.cell_valid(valid_vec[i]),
			.match_out (match_c[i+1])
		);
	end

	// The fill count tracks the valid marks of the cell row.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(n_q))
		else $error("window fill count differs from valid marks");

	// Valid cells form one run starting at cell 0.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + PATTERN_MAX'(1))) == '0)
		else $error("window valid marks are not contiguous");

	// Flushing only happens for a held last byte with bytes left.
	a_flush_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FLUSH) |-> (pend_valid_q && pend_last_q && (n_q != '0)))
		else $error("flush without a pending last byte");

	// An empty marker is always the closing beat of a text.
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("empty marker without tlast");

	// After a closing beat is produced, the window is empty.
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (n_q == '0) && (st_q == ST_RUN))
		else $error("window not empty after end of text");

endmodule
